// ===== src/lkvc_pkg.sv =====
// Shared types and constants of the LRU key/value cache.
`default_nettype none
package lkvc_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CNT_W = 11;
    localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = 11'd1000;

    typedef enum logic [1:0] {
        CMD_PROBE  = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_INSERT = 2'd2,
        CMD_TRIM   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK   = 2'd0,
        STS_MISS = 2'd1,
        STS_DUP  = 2'd2,
        STS_FULL = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_LK_RD,
        S_LK_UNL,
        S_LK_TAIL,
        S_INS_WR,
        S_LINK,
        S_TR_CHK,
        S_TR_RD,
        S_TR_EV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // APB register index taken from paddr[2]
    localparam logic REG_MAX_ENTRIES = 1'b0;

endpackage
`default_nettype wire

// ===== src/lkvc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lkvc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== src/lru_key_value_cache_core.sv =====
// Top level of the LRU key/value cache: command sequencer, recency list and APB register.
`default_nettype none
// Keyed cache of CAPACITY entries with a doubly linked recency list held in RAM.
// One command is taken at a time (o_stall is high while it runs). Probe, lookup
// and insert search the entry RAM one slot per cycle: a hit ends the search early,
// a miss scans every slot. A lookup hit on an entry that is not already the most
// recent moves it to the newest end in S_LK_RD, S_LK_UNL, S_LK_TAIL and S_LINK; an
// insert that stores writes the entry in S_INS_WR and links it in S_LINK. Trim passes
// through S_TR_CHK, S_TR_RD and S_TR_EV for each evicted entry. The search rate is
// set by the single read port of the entry RAM. After reset the entry RAM is cleared
// slot by slot and no item is taken until it is done; the max_entries register (APB,
// address 0) can be written at any time it is idle. A result waits in an output
// register until taken; the next item is accepted meanwhile.
module lru_key_value_cache_core #(
    parameter int CAPACITY = 1024
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [1:0]                  i_command,
    input  wire logic [lkvc_pkg::KEY_W-1:0]  i_key,
    input  wire logic [lkvc_pkg::VAL_W-1:0]  i_value,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [1:0]                       o_status,
    output logic [lkvc_pkg::VAL_W-1:0]       o_read_value,
    output logic [lkvc_pkg::CNT_W-1:0]       o_evicted_count,
    output logic [lkvc_pkg::CNT_W-1:0]       o_entry_count,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [2:0]                  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import lkvc_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int IW = $clog2(CAPACITY + 1);
    localparam int MW = (IW > CNT_W) ? IW : CNT_W;
    localparam logic [IW-1:0] NULL_IX = IW'(CAPACITY);
    localparam logic [AW-1:0] LAST_IX = AW'(CAPACITY - 1);

    t_state           r_state, n_state;
    logic [AW-1:0]    r_clr_addr, n_clr_addr;
    logic [IW-1:0]    r_addr, n_addr;
    logic             r_rd_vld, n_rd_vld;
    logic [AW-1:0]    r_rd_addr, n_rd_addr;
    t_cmd             r_cmd, n_cmd;
    logic [KEY_W-1:0] r_key, n_key;
    logic [VAL_W-1:0] r_value, n_value;
    logic             r_hit, n_hit;
    logic             r_scan_end, n_scan_end;
    logic [AW-1:0]    r_slot, n_slot;
    logic             r_free_ok, n_free_ok;
    logic [AW-1:0]    r_free, n_free;
    logic [VAL_W-1:0] r_rdv, n_rdv;
    t_status          r_status, n_status;
    logic [IW-1:0]    r_oldest, n_oldest;
    logic [IW-1:0]    r_newest, n_newest;
    logic [IW-1:0]    r_held, n_held;
    logic [IW-1:0]    r_evicted, n_evicted;
    logic [CNT_W-1:0] r_max, n_max;
    logic             r_o_valid, n_o_valid;
    t_status          r_o_status, n_o_status;
    logic [VAL_W-1:0] r_o_rdv, n_o_rdv;
    logic [CNT_W-1:0] r_o_evc, n_o_evc;
    logic [CNT_W-1:0] r_o_cnt, n_o_cnt;

    logic             ent_we;
    logic [AW-1:0]    ent_waddr, ent_raddr;
    t_entry           ent_wdata, ent_rdata;
    logic             prv_we, nxt_we;
    logic [AW-1:0]    prv_waddr, nxt_waddr, lnk_raddr;
    logic [IW-1:0]    prv_wdata, nxt_wdata, prv_rdata, nxt_rdata;

    logic             accept, cfg_wr, out_free, e_match, over_limit;
    logic [MW-1:0]    held_ext, evc_ext;

    lkvc_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_entry_ram (
        .i_clk(i_clk), .i_we(ent_we), .i_waddr(ent_waddr), .i_wdata(ent_wdata),
        .i_raddr(ent_raddr), .o_rdata(ent_rdata)
    );

    lkvc_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_prev_ram (
        .i_clk(i_clk), .i_we(prv_we), .i_waddr(prv_waddr), .i_wdata(prv_wdata),
        .i_raddr(lnk_raddr), .o_rdata(prv_rdata)
    );

    lkvc_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_next_ram (
        .i_clk(i_clk), .i_we(nxt_we), .i_waddr(nxt_waddr), .i_wdata(nxt_wdata),
        .i_raddr(lnk_raddr), .o_rdata(nxt_rdata)
    );

    assign accept     = i_valid && (r_state == S_IDLE);
    assign o_stall    = (r_state != S_IDLE);
    assign cfg_wr     = psel && penable && pwrite && (paddr[2] == REG_MAX_ENTRIES);
    assign out_free   = !r_o_valid || !i_stall;
    assign e_match    = ent_rdata.valid && (ent_rdata.key == r_key);
    assign held_ext   = MW'(r_held);
    assign evc_ext    = MW'(r_evicted);
    assign over_limit = (held_ext > MW'(r_max)) && (r_oldest != NULL_IX);

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_ENTRIES) ? {{(32-CNT_W){1'b0}}, r_max} : 32'd0;

    assign o_valid         = r_o_valid;
    assign o_status        = r_o_status;
    assign o_read_value    = r_o_rdv;
    assign o_evicted_count = r_o_evc;
    assign o_entry_count   = r_o_cnt;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:   if (r_clr_addr == LAST_IX) n_state = S_IDLE;
            S_IDLE: begin
                if (i_valid) begin
                    n_state = (t_cmd'(i_command) == CMD_TRIM) ? S_TR_CHK : S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_rd_vld && (e_match || r_rd_addr == LAST_IX)) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                case (r_cmd)
                    CMD_LOOKUP: n_state = (r_hit && (IW'(r_slot) != r_newest))
                                          ? S_LK_RD : S_DONE;
                    CMD_INSERT: n_state = (!r_hit && r_free_ok) ? S_INS_WR : S_DONE;
                    default:    n_state = S_DONE;
                endcase
            end
            S_LK_RD:   n_state = S_LK_UNL;
            S_LK_UNL:  n_state = S_LK_TAIL;
            S_LK_TAIL: n_state = S_LINK;
            S_INS_WR:  n_state = S_LINK;
            S_LINK:    n_state = S_DONE;
            S_TR_CHK:  n_state = over_limit ? S_TR_RD : S_DONE;
            S_TR_RD:   n_state = S_TR_EV;
            S_TR_EV:   n_state = S_TR_CHK;
            S_DONE:    if (out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath and RAM controls
    always_comb begin
        n_clr_addr = r_clr_addr;
        n_addr     = r_addr;
        n_rd_vld   = 1'b0;
        n_rd_addr  = r_addr[AW-1:0];
        n_cmd      = r_cmd;
        n_key      = r_key;
        n_value    = r_value;
        n_hit      = r_hit;
        n_scan_end = r_scan_end;
        n_slot     = r_slot;
        n_free_ok  = r_free_ok;
        n_free     = r_free;
        n_rdv      = r_rdv;
        n_status   = r_status;
        n_oldest   = r_oldest;
        n_newest   = r_newest;
        n_held     = r_held;
        n_evicted  = r_evicted;
        n_max      = cfg_wr ? pwdata[CNT_W-1:0] : r_max;
        n_o_valid  = r_o_valid && i_stall;
        n_o_status = r_o_status;
        n_o_rdv    = r_o_rdv;
        n_o_evc    = r_o_evc;
        n_o_cnt    = r_o_cnt;

        ent_we    = 1'b0;
        ent_waddr = r_slot;
        ent_wdata = '0;
        ent_raddr = r_addr[AW-1:0];
        prv_we    = 1'b0;
        prv_waddr = r_slot;
        prv_wdata = NULL_IX;
        nxt_we    = 1'b0;
        nxt_waddr = r_slot;
        nxt_wdata = NULL_IX;
        lnk_raddr = r_slot;

        case (r_state)
            S_CLEAR: begin
                ent_we     = 1'b1;
                ent_waddr  = r_clr_addr;
                n_clr_addr = r_clr_addr + 1'b1;
            end
            S_IDLE: begin
                if (accept) begin
                    n_cmd      = t_cmd'(i_command);
                    n_key      = i_key;
                    n_value    = i_value;
                    n_addr     = '0;
                    n_hit      = 1'b0;
                    n_scan_end = 1'b0;
                    n_free_ok  = 1'b0;
                    n_rdv      = '0;
                    n_evicted  = '0;
                    n_status   = STS_OK;
                end
            end
            S_SCAN: begin
                if (r_addr != NULL_IX && !r_scan_end) begin
                    n_rd_vld = 1'b1;
                    n_addr   = r_addr + 1'b1;
                end
                if (r_rd_vld) begin
                    if (!ent_rdata.valid && !r_free_ok) begin
                        n_free_ok = 1'b1;
                        n_free    = r_rd_addr;
                    end
                    if (e_match) begin
                        n_hit      = 1'b1;
                        n_slot     = r_rd_addr;
                        n_rdv      = ent_rdata.value;
                        n_scan_end = 1'b1;
                    end
                end
            end
            S_DECIDE: begin
                case (r_cmd)
                    CMD_LOOKUP: begin
                        n_status = r_hit ? STS_OK : STS_MISS;
                        if (!r_hit) n_rdv = '0;
                    end
                    CMD_INSERT: begin
                        n_rdv = '0;
                        if (r_hit) begin
                            n_status = STS_DUP;
                        end else if (!r_free_ok) begin
                            n_status = STS_FULL;
                        end else begin
                            n_slot = r_free;
                        end
                    end
                    default: begin
                        n_rdv    = '0;
                        n_status = r_hit ? STS_OK : STS_MISS;
                    end
                endcase
            end
            S_LK_UNL: begin
                if (prv_rdata != NULL_IX) begin
                    nxt_we    = 1'b1;
                    nxt_waddr = prv_rdata[AW-1:0];
                    nxt_wdata = nxt_rdata;
                end else begin
                    n_oldest = nxt_rdata;
                end
                if (nxt_rdata != NULL_IX) begin
                    prv_we    = 1'b1;
                    prv_waddr = nxt_rdata[AW-1:0];
                    prv_wdata = prv_rdata;
                end else begin
                    n_newest = prv_rdata;
                end
            end
            S_LK_TAIL: begin
                nxt_we    = 1'b1;
                prv_we    = 1'b1;
                prv_wdata = r_newest;
            end
            S_INS_WR: begin
                ent_we    = 1'b1;
                ent_wdata = '{valid: 1'b1, key: r_key, value: r_value};
                nxt_we    = 1'b1;
                prv_we    = 1'b1;
                prv_wdata = r_newest;
                n_held    = r_held + 1'b1;
            end
            S_LINK: begin
                if (r_newest != NULL_IX) begin
                    nxt_we    = 1'b1;
                    nxt_waddr = r_newest[AW-1:0];
                    nxt_wdata = IW'(r_slot);
                end else begin
                    n_oldest = IW'(r_slot);
                end
                n_newest = IW'(r_slot);
            end
            S_TR_RD: begin
                lnk_raddr = r_oldest[AW-1:0];
            end
            S_TR_EV: begin
                ent_we    = 1'b1;
                ent_waddr = r_oldest[AW-1:0];
                if (nxt_rdata != NULL_IX) begin
                    prv_we    = 1'b1;
                    prv_waddr = nxt_rdata[AW-1:0];
                end else begin
                    n_newest = NULL_IX;
                end
                n_oldest  = nxt_rdata;
                n_held    = r_held - 1'b1;
                n_evicted = r_evicted + 1'b1;
            end
            S_DONE: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_status;
                    n_o_rdv    = r_rdv;
                    n_o_evc    = evc_ext[CNT_W-1:0];
                    n_o_cnt    = held_ext[CNT_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_rd_vld   <= 1'b0;
            r_oldest   <= NULL_IX;
            r_newest   <= NULL_IX;
            r_held     <= '0;
            r_max      <= MAX_ENTRIES_RST;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_rd_vld   <= n_rd_vld;
            r_oldest   <= n_oldest;
            r_newest   <= n_newest;
            r_held     <= n_held;
            r_max      <= n_max;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_rd_addr  <= n_rd_addr;
        r_cmd      <= n_cmd;
        r_key      <= n_key;
        r_value    <= n_value;
        r_hit      <= n_hit;
        r_scan_end <= n_scan_end;
        r_slot     <= n_slot;
        r_free_ok  <= n_free_ok;
        r_free     <= n_free;
        r_rdv      <= n_rdv;
        r_status   <= n_status;
        r_evicted  <= n_evicted;
        r_o_status <= n_o_status;
        r_o_rdv    <= n_o_rdv;
        r_o_evc    <= n_o_evc;
        r_o_cnt    <= n_o_cnt;
    end

endmodule
`default_nettype wire

// ===== tb/tb_lru_key_value_cache_core.sv =====
// Testbench for the LRU key/value cache core: directed and random commands checked by a scoreboard.
`default_nettype none
import lkvc_pkg::*;

typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] read_value;
    logic [CNT_W-1:0] evicted_count;
    logic [CNT_W-1:0] entry_count;
} t_cache_result;

class cache_scoreboard;
    localparam int SLOTS = 1024;
    localparam int NIL = SLOTS;
    logic [KEY_W-1:0] keys[SLOTS];
    logic [VAL_W-1:0] vals[SLOTS];
    bit               used[SLOTS];
    int               older[SLOTS];
    int               newer[SLOTS];
    int               oldest, newest, held;
    int unsigned      limit;
    t_cache_result    pending[$];
    int               errors;

    function new();
        for (int i = 0; i < SLOTS; i++) used[i] = 0;
        oldest = NIL; newest = NIL; held = 0; limit = MAX_ENTRIES_RST; errors = 0;
    endfunction

    function int find_key(logic [KEY_W-1:0] k);
        for (int i = 0; i < SLOTS; i++)
            if (used[i] && keys[i] == k) return i;
        return NIL;
    endfunction

    function void unlink(int i);
        if (older[i] != NIL) newer[older[i]] = newer[i]; else oldest = newer[i];
        if (newer[i] != NIL) older[newer[i]] = older[i]; else newest = older[i];
    endfunction

    function void append(int i);
        newer[i] = NIL;
        older[i] = newest;
        if (newest != NIL) newer[newest] = i; else oldest = i;
        newest = i;
    endfunction

    function void note_item(t_cmd cmd, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
        t_cache_result r;
        int s;
        r = '0;
        case (cmd)
            CMD_PROBE: r.status = (find_key(k) != NIL) ? STS_OK : STS_MISS;
            CMD_LOOKUP: begin
                s = find_key(k);
                if (s != NIL) begin
                    r.read_value = vals[s];
                    if (s != newest) begin
                        unlink(s);
                        append(s);
                    end
                end else begin
                    r.status = STS_MISS;
                end
            end
            CMD_INSERT: begin
                if (find_key(k) != NIL) begin
                    r.status = STS_DUP;
                end else begin
                    s = NIL;
                    for (int i = SLOTS - 1; i >= 0; i--) if (!used[i]) s = i;
                    if (s == NIL) begin
                        r.status = STS_FULL;
                    end else begin
                        keys[s] = k; vals[s] = v; used[s] = 1;
                        append(s);
                        held++;
                    end
                end
            end
            default: begin
                while (held > limit && oldest != NIL) begin
                    s = oldest;
                    unlink(s);
                    used[s] = 0;
                    held--;
                    r.evicted_count++;
                end
            end
        endcase
        r.entry_count = CNT_W'(held);
        pending.push_back(r);
    endfunction

    function void check_result(t_cache_result got);
        t_cache_result want;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.status !== want.status) begin
            $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
            errors++;
        end
        if (got.read_value !== want.read_value) begin
            $display("%0t: read_value exp %h got %h", $time, want.read_value, got.read_value);
            errors++;
        end
        if (got.evicted_count !== want.evicted_count) begin
            $display("%0t: evicted exp %0d got %0d", $time, want.evicted_count,
                     got.evicted_count);
            errors++;
        end
        if (got.entry_count !== want.entry_count) begin
            $display("%0t: count exp %0d got %0d", $time, want.entry_count, got.entry_count);
            errors++;
        end
    endfunction
endclass

module tb_lru_key_value_cache_core;
    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              i_valid = 0;
    logic              o_stall;
    logic [1:0]        i_command = '0;
    logic [KEY_W-1:0]  i_key = '0;
    logic [VAL_W-1:0]  i_value = '0;
    logic              o_valid;
    logic              i_stall = 0;
    logic [1:0]        o_status;
    logic [VAL_W-1:0]  o_read_value;
    logic [CNT_W-1:0]  o_evicted_count;
    logic [CNT_W-1:0]  o_entry_count;
    logic              psel = 0, penable = 0, pwrite = 0;
    logic [2:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    cache_scoreboard   board = new();
    logic [KEY_W-1:0]  known_keys[$];
    bit                calm = 0;

    lru_key_value_cache_core i_dut (.*);

    always #5 i_clk = ~i_clk;

    // receiver: random stall bursts, result checked on acceptance
    initial begin
        int gap;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall)
                board.check_result({o_status, o_read_value, o_evicted_count, o_entry_count});
            if (i_stall) begin
                if (gap > 0) gap--; else i_stall <= 0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(0, 6);
                i_stall <= 1;
            end
        end
    end

    // valid stays high after acceptance until the next item or an idle period drops it
    task automatic send_item(t_cmd cmd, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_valid <= 1;
        i_command <= cmd;
        i_key <= k;
        i_value <= v;
        do @(posedge i_clk); while (o_stall);
        board.note_item(cmd, k, v);
        if (cmd == CMD_INSERT) known_keys.push_back(k);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [CNT_W-1:0] lim);
        drain();
        psel <= 1; pwrite <= 1; paddr <= {REG_MAX_ENTRIES, 2'b00}; pwdata <= 32'(lim);
        @(posedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        psel <= 0; penable <= 0; pwrite <= 0;
        board.limit = lim;
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if (known_keys.size() != 0 && $urandom_range(0, 3) != 0)
            return known_keys[$urandom_range(0, known_keys.size() - 1)];
        return $urandom();
    endfunction

    initial begin
        t_cmd cmd;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        write_limit(3);
        send_item(CMD_PROBE, 32'h0, 32'h0);
        send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        send_item(CMD_INSERT, 32'h0, 32'hFFFF_FFFF);
        send_item(CMD_INSERT, 32'hFFFF_FFFF, 32'h0);
        send_item(CMD_INSERT, 32'h0, 32'h1234_5678);
        send_item(CMD_PROBE, 32'h0, 32'h0);
        send_item(CMD_LOOKUP, 32'h0, 32'h0);
        send_item(CMD_INSERT, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        send_item(CMD_INSERT, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
        send_item(CMD_TRIM, 32'h0, 32'h0);
        send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        send_item(CMD_TRIM, 32'h0, 32'h0);
        write_limit(0);
        send_item(CMD_TRIM, 32'h0, 32'h0);
        send_item(CMD_TRIM, 32'h0, 32'h0);
        write_limit(11'h7FF);
        send_item(CMD_INSERT, 32'h1, 32'h1);
        send_item(CMD_TRIM, 32'h1, 32'h0);
        write_limit(1024);
        send_item(CMD_INSERT, 32'h7777_7777, 32'h1);
        send_item(CMD_LOOKUP, 32'h8000_0000, 32'h0);
        write_limit(1);
        send_item(CMD_TRIM, 32'h0, 32'h0);
        for (int ph = 0; ph < 4; ph++) begin
            write_limit(ph == 3 ? 11'd2 : 11'($urandom_range(1, 12)));
            for (int n = 0; n < 140; n++) begin
                if (ph == 3 && n > 100) calm = 1;
                case ($urandom_range(0, 9))
                    0, 1: cmd = CMD_PROBE;
                    2, 3, 4: cmd = CMD_LOOKUP;
                    5, 6, 7, 8: cmd = CMD_INSERT;
                    default: cmd = CMD_TRIM;
                endcase
                send_item(cmd, pick_key(), $urandom());
                if (n == 70) drain();
            end
        end
        drain();
        if (board.errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

    initial begin
        #60000000;
        $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
